### rtl/core/e2r_pkg.sv
// Shared constants, types and arithmetic helpers for the Euler-to-rotation-matrix block
package e2r_pkg;

    localparam int ANGLE_FRAC_BITS = 13;
    localparam int COEF_FRAC_BITS  = 14;

    localparam int FIELD_W      = 16;
    localparam int Q_FRAC       = 30;
    localparam int SERIES_TERMS = 12;

    localparam int ANG_SH = Q_FRAC - ANGLE_FRAC_BITS;
    localparam int MAG_W  = (FIELD_W + 1 + ANG_SH > 33) ? FIELD_W + 1 + ANG_SH : 33;

    localparam logic [32:0] PI_Q30      = 33'd3373259426;
    localparam logic [32:0] HALF_PI_Q30 = 33'd1686629713;
    localparam logic [31:0] ONE_Q30     = 32'd1 << Q_FRAC;

    localparam int TRIG_LAT  = 4 + 3 * SERIES_TERMS;
    localparam int MERGE_LAT = 4;
    localparam int E2R_LAT   = TRIG_LAT + MERGE_LAT;

    localparam int          OUT_SH  = Q_FRAC - COEF_FRAC_BITS;
    localparam logic [33:0] OUT_RND = (34'd1 << OUT_SH) >> 1;
    localparam logic [33:0] OUT_LIM = 34'd1 << COEF_FRAC_BITS;

    typedef struct packed {
        logic [31:0] x2;
        logic        neg;
        logic        cneg;
    } e2r_ctl_t;

    function automatic logic signed [31:0] qmul(input logic signed [31:0] a,
                                                input logic signed [31:0] b);
        logic [31:0] ma;
        logic [31:0] mb;
        logic [63:0] p;
        logic [31:0] pm;
        ma = a[31] ? 32'(-a) : 32'(a);
        mb = b[31] ? 32'(-b) : 32'(b);
        p  = 64'(ma) * 64'(mb) + (64'd1 << (Q_FRAC - 1));
        pm = 32'(p >> Q_FRAC);
        return (a[31] ^ b[31]) ? 32'(-signed'(pm)) : signed'(pm);
    endfunction

    function automatic logic [FIELD_W-1:0] emit(input logic signed [32:0] v);
        logic [33:0] mag;
        logic [33:0] m;
        mag = v[32] ? 34'(-35'(v)) : 34'(v);
        m   = (mag + OUT_RND) >> OUT_SH;
        if (m > OUT_LIM) begin
            m = OUT_LIM;
        end
        return v[32] ? FIELD_W'(-m) : FIELD_W'(m);
    endfunction

endpackage

### rtl/core/e2r_trig.sv
// Sine and cosine lane: range reduction and a pipelined truncated Taylor series
module e2r_trig (
    input  logic               aclk,
    input  logic               en,
    input  logic signed [15:0] angle,
    output logic signed [31:0] sin_q,
    output logic signed [31:0] cos_q
);

    localparam int N = e2r_pkg::SERIES_TERMS;
    localparam int W = e2r_pkg::MAG_W;

    logic [15:0] ang_reg;
    logic [16:0] mag17;
    logic [W-1:0] shifted;
    logic [W-1:0] capped;
    logic [30:0] m_next;
    logic        cneg_next;
    logic [30:0] m_reg;
    logic        neg_reg;
    logic        cneg_reg;
    logic [61:0] sq;

    e2r_pkg::e2r_ctl_t ctl_c [0:N];
    e2r_pkg::e2r_ctl_t ctl_a [1:N];
    e2r_pkg::e2r_ctl_t ctl_b [1:N];
    logic [31:0]        term_c [0:N][0:1];
    logic signed [33:0] sum_c  [0:N][0:1];
    logic [31:0]        prod_a [1:N][0:1];
    logic signed [33:0] sum_a  [1:N][0:1];
    logic [31:0]        n_b    [1:N][0:1];
    logic [31:0]        q0_b   [1:N][0:1];
    logic signed [33:0] sum_b  [1:N][0:1];

    logic [30:0] sv;
    logic [30:0] cv;

    always_ff @(posedge aclk) begin
        if (en) begin
            ang_reg <= angle;
        end
    end

    always_comb begin
        mag17   = ang_reg[15] ? (17'h10000 - {1'b0, ang_reg}) : {1'b0, ang_reg};
        shifted = W'(mag17) << e2r_pkg::ANG_SH;
        capped  = (shifted > W'(e2r_pkg::PI_Q30)) ? W'(e2r_pkg::PI_Q30) : shifted;
        if (capped > W'(e2r_pkg::HALF_PI_Q30)) begin
            m_next    = 31'(W'(e2r_pkg::PI_Q30) - capped);
            cneg_next = 1'b1;
        end else begin
            m_next    = 31'(capped);
            cneg_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_reg    <= m_next;
            neg_reg  <= ang_reg[15];
            cneg_reg <= cneg_next;
        end
    end

    assign sq = 62'(m_reg) * 62'(m_reg);

    always_ff @(posedge aclk) begin
        if (en) begin
            ctl_c[0].x2   <= sq[61:30];
            ctl_c[0].neg  <= neg_reg;
            ctl_c[0].cneg <= cneg_reg;
            term_c[0][0]  <= 32'(m_reg);
            term_c[0][1]  <= e2r_pkg::ONE_Q30;
            sum_c[0][0]   <= 34'(m_reg);
            sum_c[0][1]   <= 34'(e2r_pkg::ONE_Q30);
        end
    end

    for (genvar k = 1; k <= N; k++) begin : g_step
        always_ff @(posedge aclk) begin
            if (en) begin
                ctl_a[k] <= ctl_c[k-1];
                ctl_b[k] <= ctl_a[k];
                ctl_c[k] <= ctl_b[k];
            end
        end

        for (genvar j = 0; j < 2; j++) begin : g_fn
            localparam int D = (j == 0) ? (2 * k) * (2 * k + 1) : (2 * k - 1) * (2 * k);
            localparam int S = 31 + $clog2(D + 1) - 1;
            localparam logic [31:0] R = 32'((64'd1 << S) / D);

            logic [63:0] mul_a;
            logic [63:0] mul_b;
            logic [41:0] qd;
            logic [41:0] rem;
            logic [31:0] term_next;

            assign mul_a = 64'(term_c[k-1][j]) * 64'(ctl_c[k-1].x2);
            assign mul_b = 64'(prod_a[k][j]) * 64'(R);
            assign qd    = 42'(q0_b[k][j]) * 42'(D);
            assign rem   = 42'(n_b[k][j]) - qd;
            assign term_next = (rem >= 42'(D)) ? q0_b[k][j] + 32'd1 : q0_b[k][j];

            always_ff @(posedge aclk) begin
                if (en) begin
                    prod_a[k][j] <= mul_a[61:30];
                    sum_a[k][j]  <= sum_c[k-1][j];
                    n_b[k][j]    <= prod_a[k][j];
                    q0_b[k][j]   <= 32'(mul_b >> S);
                    sum_b[k][j]  <= sum_a[k][j];
                    term_c[k][j] <= term_next;
                    if (k % 2 == 1) begin
                        sum_c[k][j] <= sum_b[k][j] - 34'(term_next);
                    end else begin
                        sum_c[k][j] <= sum_b[k][j] + 34'(term_next);
                    end
                end
            end
        end
    end

    always_comb begin
        if (sum_c[N][0] < 0) begin
            sv = '0;
        end else if (sum_c[N][0] > 34'(e2r_pkg::ONE_Q30)) begin
            sv = 31'(e2r_pkg::ONE_Q30);
        end else begin
            sv = 31'(sum_c[N][0]);
        end
        if (sum_c[N][1] < 0) begin
            cv = '0;
        end else if (sum_c[N][1] > 34'(e2r_pkg::ONE_Q30)) begin
            cv = 31'(e2r_pkg::ONE_Q30);
        end else begin
            cv = 31'(sum_c[N][1]);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sin_q <= ctl_c[N].neg  ? -32'(sv) : 32'(sv);
            cos_q <= ctl_c[N].cneg ? -32'(cv) : 32'(cv);
        end
    end

endmodule

### rtl/core/e2r_merge.sv
// Merging stage: products, sums, rounding and saturation of the nine matrix entries
module e2r_merge (
    input  logic               aclk,
    input  logic               en,
    input  logic signed [31:0] s1,
    input  logic signed [31:0] c1,
    input  logic signed [31:0] s2,
    input  logic signed [31:0] c2,
    input  logic signed [31:0] s3,
    input  logic signed [31:0] c3,
    output logic [15:0]        r00,
    output logic [15:0]        r01,
    output logic [15:0]        r02,
    output logic [15:0]        r10,
    output logic [15:0]        r11,
    output logic [15:0]        r12,
    output logic [15:0]        r20,
    output logic [15:0]        r21,
    output logic [15:0]        r22
);

    logic signed [31:0] p_reg, q_reg;
    logic signed [31:0] c2c3_reg, c2s3_reg, c1s3_reg, c1c3_reg, c2s1_reg;
    logic signed [31:0] s1s3_reg, c3s1_reg, c1c2_reg, s2_reg, s3_reg, c3_reg;
    logic signed [31:0] c2c3_b, c2s3_b, c1s3_b, c1c3_b, c2s1_b;
    logic signed [31:0] s1s3_b, c3s1_b, c1c2_b, s2_b;
    logic signed [31:0] c3p_reg, ps3_reg, qc3_reg, qs3_reg;
    logic signed [32:0] e_reg [0:8];

    always_ff @(posedge aclk) begin
        if (en) begin
            p_reg    <= e2r_pkg::qmul(s1, s2);
            q_reg    <= e2r_pkg::qmul(c1, s2);
            c2c3_reg <= e2r_pkg::qmul(c2, c3);
            c2s3_reg <= e2r_pkg::qmul(c2, s3);
            c1s3_reg <= e2r_pkg::qmul(c1, s3);
            c1c3_reg <= e2r_pkg::qmul(c1, c3);
            c2s1_reg <= e2r_pkg::qmul(c2, s1);
            s1s3_reg <= e2r_pkg::qmul(s1, s3);
            c3s1_reg <= e2r_pkg::qmul(c3, s1);
            c1c2_reg <= e2r_pkg::qmul(c1, c2);
            s2_reg   <= s2;
            s3_reg   <= s3;
            c3_reg   <= c3;

            c3p_reg <= e2r_pkg::qmul(c3_reg, p_reg);
            ps3_reg <= e2r_pkg::qmul(p_reg, s3_reg);
            qc3_reg <= e2r_pkg::qmul(q_reg, c3_reg);
            qs3_reg <= e2r_pkg::qmul(q_reg, s3_reg);
            c2c3_b  <= c2c3_reg;
            c2s3_b  <= c2s3_reg;
            c1s3_b  <= c1s3_reg;
            c1c3_b  <= c1c3_reg;
            c2s1_b  <= c2s1_reg;
            s1s3_b  <= s1s3_reg;
            c3s1_b  <= c3s1_reg;
            c1c2_b  <= c1c2_reg;
            s2_b    <= s2_reg;

            e_reg[0] <= 33'(c2c3_b);
            e_reg[1] <= -33'(c2s3_b);
            e_reg[2] <= 33'(s2_b);
            e_reg[3] <= 33'(c1s3_b) + 33'(c3p_reg);
            e_reg[4] <= 33'(c1c3_b) - 33'(ps3_reg);
            e_reg[5] <= -33'(c2s1_b);
            e_reg[6] <= 33'(s1s3_b) - 33'(qc3_reg);
            e_reg[7] <= 33'(c3s1_b) + 33'(qs3_reg);
            e_reg[8] <= 33'(c1c2_b);

            r00 <= e2r_pkg::emit(e_reg[0]);
            r01 <= e2r_pkg::emit(e_reg[1]);
            r02 <= e2r_pkg::emit(e_reg[2]);
            r10 <= e2r_pkg::emit(e_reg[3]);
            r11 <= e2r_pkg::emit(e_reg[4]);
            r12 <= e2r_pkg::emit(e_reg[5]);
            r20 <= e2r_pkg::emit(e_reg[6]);
            r21 <= e2r_pkg::emit(e_reg[7]);
            r22 <= e2r_pkg::emit(e_reg[8]);
        end
    end

endmodule

### rtl/core/euler_to_rotation_matrix.sv
// Top level: XYZ Euler angles to 3x3 rotation matrix, three trig lanes and a merging stage
//
// Input channel s_*: three signed Q3.13 angles per transfer (s_angle_x/y/z).
// Output channel m_*: nine signed Q2.14 matrix entries per transfer.
// Each input transfer yields exactly one output transfer, in order.
// The trig lanes end in a Taylor series that takes three stages per term, and
// the merging stage follows them; m_valid travels along with its result.
// Throughput: one transfer per cycle unless stalled; the whole pipeline advances together.
// When the receiver stalls with a result held, every stage holds and s_ready
// drops in the same cycle; results are never lost or repeated.
// Reset (aresetn low, synchronous) clears the valid pipeline; data registers
// are not reset. The block keeps no state between transfers.
module euler_to_rotation_matrix (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [15:0] s_angle_x,
    input  logic [15:0] s_angle_y,
    input  logic [15:0] s_angle_z,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [15:0] m_r00,
    output logic [15:0] m_r01,
    output logic [15:0] m_r02,
    output logic [15:0] m_r10,
    output logic [15:0] m_r11,
    output logic [15:0] m_r12,
    output logic [15:0] m_r20,
    output logic [15:0] m_r21,
    output logic [15:0] m_r22
);

    localparam int LAT = e2r_pkg::E2R_LAT;

    logic [LAT-1:0] vld_reg;
    logic [LAT-1:0] vld_next;
    logic           en;
    logic signed [31:0] s1, c1, s2, c2, s3, c3;

    assign m_valid = vld_reg[LAT-1];
    assign en      = !m_valid || m_ready;
    assign s_ready = en;

    always_comb begin
        vld_next = vld_reg;
        if (en) begin
            vld_next = {vld_reg[LAT-2:0], s_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    e2r_trig u_trig_x (.aclk(aclk), .en(en), .angle(s_angle_x), .sin_q(s1), .cos_q(c1));
    e2r_trig u_trig_y (.aclk(aclk), .en(en), .angle(s_angle_y), .sin_q(s2), .cos_q(c2));
    e2r_trig u_trig_z (.aclk(aclk), .en(en), .angle(s_angle_z), .sin_q(s3), .cos_q(c3));

    e2r_merge u_merge (
        .aclk(aclk), .en(en),
        .s1(s1), .c1(c1), .s2(s2), .c2(c2), .s3(s3), .c3(c3),
        .r00(m_r00), .r01(m_r01), .r02(m_r02),
        .r10(m_r10), .r11(m_r11), .r12(m_r12),
        .r20(m_r20), .r21(m_r21), .r22(m_r22)
    );

    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> $stable(vld_reg))
        else $error("valid pipeline moved during stall");

    a_stall_blocks_input: assert property (@(posedge aclk)
        m_valid && !m_ready |-> !s_ready)
        else $error("input taken while result stalled");

    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule
